>>> hw/rtl/esd_pkg.sv
// Shared types, register indexes and the per-client parser step for the
// escaped stream demultiplexer. No dependencies.

package esd_pkg;

	localparam int CLIENT_W    = 5;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int RESQ_DEPTH  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_CODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SMART_MASK  = 2'd1;

	localparam logic [7:0] ESCAPE_RESET = 8'd128;
	localparam logic [7:0] RESULT_MARK_OFFSET = 8'd3;

	typedef enum logic [1:0] {
		PS_PLAIN,
		PS_ESC,
		PS_CTRL,
		PS_RESULT
	} parse_t;

	// One byte handed to a client, without its client number.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       kind;
		logic       message_end;
	} emit_t;

	// Outcome of feeding one byte into a client parser.
	typedef struct packed {
		parse_t     ps;
		logic [1:0] n;
		emit_t      e0;
		emit_t      e1;
	} feed_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] client_index;
		logic [7:0]          out_byte;
		logic                kind;
		logic                message_end;
		logic                bad_switch;
		logic                last;
	} result_t;

	// Results of one link byte, handed from the core to the result queue.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic feed_t client_feed(parse_t ps, logic [7:0] x, logic [7:0] e,
	                                      logic smart);
		feed_t      f;
		logic [7:0] rm;
		rm   = e - RESULT_MARK_OFFSET;
		f.ps = ps;
		f.n  = 2'd0;
		f.e0 = '0;
		f.e1 = '0;
		case (ps)
			PS_PLAIN: begin
				if (x == e) begin
					f.ps = PS_ESC;
				end else begin
					f.n  = 2'd1;
					f.e0 = '{out_byte: x, kind: 1'b0, message_end: 1'b0};
				end
			end
			PS_ESC: begin
				if (x == e) begin
					f.n  = 2'd1;
					f.e0 = '{out_byte: e, kind: 1'b0, message_end: 1'b0};
					f.ps = PS_PLAIN;
				end else if (x == rm) begin
					if (smart) begin
						f.n  = 2'd2;
						f.e0 = '{out_byte: e, kind: 1'b0, message_end: 1'b0};
						f.e1 = '{out_byte: rm, kind: 1'b0, message_end: 1'b0};
					end
					f.ps = PS_RESULT;
				end else begin
					f.ps = PS_CTRL;
				end
			end
			PS_CTRL: begin
				f.n  = 2'd1;
				f.e0 = '{out_byte: x, kind: 1'b1, message_end: (x == 8'd0)};
				if (x == 8'd0) begin
					f.ps = PS_PLAIN;
				end
			end
			default: begin
				if (smart) begin
					f.n  = 2'd1;
					f.e0 = '{out_byte: x, kind: 1'b0, message_end: 1'b0};
				end
				if (x == 8'd0) begin
					f.ps = PS_PLAIN;
				end
			end
		endcase
		return f;
	endfunction

endpackage

>>> hw/rtl/esd_core.sv
// Link escape decoding, client switching and per-client parsers.
// Depends on esd_pkg.

module esd_core #(
	parameter int NUM_CLIENTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           link_byte,
	input  logic [7:0]           escape_code,
	input  logic [31:0]          smart_mask,
	output esd_pkg::push_t       push
);

	localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

	logic            esc_seen_q;
	logic            cur_valid_q;
	logic [CW-1:0]   cur_q;
	esd_pkg::parse_t ps_q [NUM_CLIENTS];
	logic [NUM_CLIENTS-1:0] open_q;

	logic            smart;
	esd_pkg::parse_t ps_cur;
	logic            is_esc, above, in_range;
	logic [7:0]      sw_idx, first;
	logic [CW-1:0]   sw_sel;
	esd_pkg::feed_t  fa, fb;
	logic            do_single, do_double, do_switch;
	esd_pkg::emit_t  s0, s1;
	logic [1:0]      n;
	logic [esd_pkg::CLIENT_W-1:0] cur_ext;

	always_comb begin
		smart   = smart_mask[cur_q];
		ps_cur  = ps_q[cur_q];
		is_esc  = (link_byte == escape_code);
		above   = (link_byte > escape_code);
		sw_idx  = link_byte - escape_code - 8'd1;
		sw_sel  = sw_idx[CW-1:0];
		in_range = (sw_idx < 8'(NUM_CLIENTS));
		// After a link escape, the parser first sees the escape itself.
		first   = esc_seen_q ? escape_code : link_byte;
		fa      = esd_pkg::client_feed(ps_cur, first, escape_code, smart);
		fb      = esd_pkg::client_feed(fa.ps, link_byte, escape_code, smart);
		do_single = !esc_seen_q && !is_esc && cur_valid_q;
		do_double = esc_seen_q && !above && cur_valid_q;
		do_switch = esc_seen_q && above;
		cur_ext = esd_pkg::CLIENT_W'(cur_q);

		s0 = '0;
		s1 = '0;
		n  = 2'd0;
		if (do_single) begin
			n  = fa.n;
			s0 = fa.e0;
			s1 = fa.e1;
		end else if (do_double) begin
			// At most two bytes come out of the pair of parser steps.
			n  = fa.n + fb.n;
			s0 = (fa.n != 2'd0) ? fa.e0 : fb.e0;
			s1 = (fa.n == 2'd2) ? fa.e1 : ((fa.n == 2'd1) ? fb.e0 : fb.e1);
		end

		push = '0;
		if (do_switch && !in_range) begin
			push.n  = 2'd1;
			push.r0 = '{client_index: '0, out_byte: link_byte, kind: 1'b0,
			            message_end: 1'b0, bad_switch: 1'b1, last: 1'b1};
		end else begin
			push.n  = n;
			push.r0 = '{client_index: cur_ext, out_byte: s0.out_byte, kind: s0.kind,
			            message_end: s0.message_end, bad_switch: 1'b0,
			            last: (n == 2'd1)};
			push.r1 = '{client_index: cur_ext, out_byte: s1.out_byte, kind: s1.kind,
			            message_end: s1.message_end, bad_switch: 1'b0, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_seen_q  <= 1'b0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			open_q      <= '0;
			for (int i = 0; i < NUM_CLIENTS; i++) begin
				ps_q[i] <= esd_pkg::PS_PLAIN;
			end
		end else if (step) begin
			esc_seen_q <= !esc_seen_q && is_esc;
			if (do_switch && in_range) begin
				cur_q       <= sw_sel;
				cur_valid_q <= 1'b1;
				if (!open_q[sw_sel]) begin
					open_q[sw_sel] <= 1'b1;
					ps_q[sw_sel]   <= esd_pkg::PS_PLAIN;
				end
			end
			if (do_single) begin
				ps_q[cur_q] <= fa.ps;
			end
			if (do_double) begin
				ps_q[cur_q] <= fb.ps;
			end
		end
	end

endmodule

>>> hw/rtl/esd_resq.sv
// Small result queue: takes up to two results per cycle, hands out one when not stalled.
// Depends on esd_pkg.

module esd_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  esd_pkg::push_t   push,
	output logic             room,
	output logic             res_valid,
	input  logic             res_stall,
	output esd_pkg::result_t head
);

	localparam int DEPTH = esd_pkg::RESQ_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = PW + 1;

	esd_pkg::result_t mem [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             pop;

	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	// Room for a worst-case pair of results.
	assign room      = (cnt_q <= CNTW'(DEPTH - 2));
	assign head      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_q + PW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push.n);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CNTW'(push.n) - CNTW'(pop);
		end
	end

endmodule

>>> hw/rtl/escaped_stream_demultiplexer.sv
// Escaped stream demultiplexer, top level.
// Depends on esd_pkg, esd_core and esd_resq.
// Usage: link bytes arrive on the link channel (link_valid, link_stall,
// link_byte); each accepted request is one byte of the escape-coded stream.
// Result requests leave on the result channel (res_valid, res_stall and the
// payload ports): client, byte, control-message flag, end-of-message flag,
// bad-switch flag and last-result flag. A link byte gives zero to two results.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the escape code (index 0) and the smart mask (index 1); cfg_ready is always
// high, and writes are meant to happen while the block is idle.
// A byte accepted into the input register is processed by the core once the
// queue has room; its results enter the result queue, whose head is offered
// on the result channel. Throughput is one link byte per cycle while the
// queue has room, set by the single processing stage; a byte with two results
// has them offered in turn, and a four-entry result queue absorbs the
// difference, stalling the link once it lacks room for two more results.
// Reset clears the escape state, deselects and closes every client, empties
// the queue and restores the escape code to 128 and the mask to zero. When the
// receiver stalls, the head result holds still and the queue fills.

module escaped_stream_demultiplexer #(
	parameter int NUM_CLIENTS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              link_valid,
	output logic                              link_stall,
	input  logic [7:0]                        link_byte,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [esd_pkg::CLIENT_W-1:0]      client_index,
	output logic [7:0]                        out_byte,
	output logic                              kind,
	output logic                              message_end,
	output logic                              bad_switch,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [esd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [esd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [7:0]       escape_q;
	logic [31:0]      smart_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             room;
	logic             advance;
	logic             accept;
	esd_pkg::push_t   push;
	esd_pkg::result_t head;

	// The input register moves on only when the queue can take a full pair.
	assign advance    = valid_s1 && room;
	assign link_stall = valid_s1 && !room;
	assign accept     = link_valid && !link_stall;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= esd_pkg::ESCAPE_RESET;
			smart_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				esd_pkg::REG_ESCAPE_CODE: escape_q <= cfg_data[7:0];
				esd_pkg::REG_SMART_MASK:  smart_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= link_byte;
		end
	end

	esd_core #(
		.NUM_CLIENTS (NUM_CLIENTS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.link_byte   (byte_s1),
		.escape_code (escape_q),
		.smart_mask  (smart_q),
		.push        (push)
	);

	esd_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance ? push : '0),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.head      (head)
	);

	assign client_index = head.client_index;
	assign out_byte     = head.out_byte;
	assign kind         = head.kind;
	assign message_end  = head.message_end;
	assign bad_switch   = head.bad_switch;
	assign last         = head.last;

endmodule
